// ===== hdl/stepper_phase_sequencer_macros.svh =====
// Assertion helpers for the stepper sequencer.
// Both sample on clk and are disabled while rst_n is low.
`ifndef STEPPER_PHASE_SEQUENCER_MACROS_SVH
`define STEPPER_PHASE_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define SPS_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sps assertion failed");

// Next-cycle implication.
`define SPS_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sps assertion failed");

`endif

// ===== hdl/sps_pkg.sv =====
package sps_pkg;

    localparam int TICKS_PER_STEP_DEF = 40;
    localparam int POS_WIDTH_DEF      = 16;

    // Command codes
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_HOME   = 2'd1;
    localparam logic [1:0] ACT_TARGET = 2'd2;
    localparam logic [1:0] ACT_OFFSET = 2'd3;

    // Drive modes; code 3 freezes the phase
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_WAVE   = 2'd1;
    localparam logic [1:0] MODE_HALF   = 2'd2;

    // Register indexes on the config port
    localparam logic [2:0] REG_DRIVE_MODE     = 3'd0;
    localparam logic [2:0] REG_OVERSHOOT      = 3'd1;
    localparam logic [2:0] REG_MAX_HOME       = 3'd2;
    localparam logic [2:0] REG_POS_DARK       = 3'd3;
    localparam logic [2:0] REG_POS_REFERENCE  = 3'd4;
    localparam logic [2:0] REG_POS_PROD_START = 3'd5;
    localparam logic [2:0] REG_POS_PROD_END   = 3'd6;

    // Register reset values
    localparam logic [1:0]  DRIVE_MODE_RST     = MODE_HALF;
    localparam logic [7:0]  OVERSHOOT_RST      = 8'd0;
    localparam logic [14:0] MAX_HOME_RST       = 15'd32500;
    localparam logic [15:0] POS_DARK_RST       = 16'd0;
    localparam logic [15:0] POS_REFERENCE_RST  = 16'd10;
    localparam logic [15:0] POS_PROD_START_RST = 16'd20;
    localparam logic [15:0] POS_PROD_END_RST   = 16'd30;

    localparam logic [3:0] PHASE_RST = 4'd1;

    typedef struct packed {
        logic [1:0]        action;
        logic [1:0]        target_select;
        logic signed [15:0] offset_steps;
        logic              at_home;
    } sps_cmd_t;

    typedef struct packed {
        logic [3:0]         phase;
        logic               phase_apply;
        logic               release_res;
        logic               moving;
        logic signed [15:0] position;
        logic signed [15:0] pending;
    } sps_res_t;

    typedef struct packed {
        logic [1:0]       drive_mode;
        logic [7:0]       overshoot_steps;
        logic [14:0]      max_home_steps;
        logic [3:0][15:0] pos_target;
    } sps_cfg_t;

    typedef struct packed {
        logic apply;
        logic release_hit;
    } sps_flags_t;

    // Phase 1..8 advanced one step; toward home moves up, away moves down.
    function automatic logic [3:0] sps_next_phase(input logic [3:0] p,
                                                  input logic [1:0] mode,
                                                  input logic toward_home);
        logic [2:0] d;
        logic [2:0] stp;
        logic [2:0] base;
        logic [2:0] sum;
        logic       keep;
        d    = 3'd1;
        keep = 1'b0;
        unique case (mode)
            MODE_NORMAL: d = p[0] ? 3'd2 : 3'd1;
            MODE_WAVE:   d = p[0] ? 3'd1 : 3'd2;
            MODE_HALF:   d = 3'd1;
            default:     keep = 1'b1;
        endcase
        stp  = toward_home ? d : (3'd0 - d);
        base = 3'(p - 4'd1);
        sum  = base + stp;
        return keep ? p : ({1'b0, sum} + 4'd1);
    endfunction

endpackage

// ===== hdl/sps_cmd_if.sv =====
interface sps_cmd_if import sps_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [1:0]         target_select;
    logic signed [15:0] offset_steps;
    logic               at_home;

    modport source (output valid, action, target_select, offset_steps, at_home,
                    input ready);
    modport sink   (input valid, action, target_select, offset_steps, at_home,
                    output ready);
endinterface

// ===== hdl/sps_res_if.sv =====
interface sps_res_if import sps_pkg::*;;
    logic               valid;
    logic               ready;
    logic [3:0]         phase;
    logic               phase_apply;
    logic               release_res;
    logic               moving;
    logic signed [15:0] position;
    logic signed [15:0] pending;

    modport source (output valid, phase, phase_apply, release_res, moving, position, pending,
                    input ready);
    modport sink   (input valid, phase, phase_apply, release_res, moving, position, pending,
                    output ready);
endinterface

// ===== hdl/sps_cfg_if.sv =====
interface sps_cfg_if import sps_pkg::*;;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/sps_step.sv =====
module sps_step
    import sps_pkg::*;
#(
    parameter int TICKS_PER_STEP = TICKS_PER_STEP_DEF,
    parameter int POS_WIDTH      = POS_WIDTH_DEF,
    localparam int DIV_W         = $clog2(TICKS_PER_STEP + 1)
)
(
    input  sps_cfg_t               cfg,
    input  sps_cmd_t               cmd,
    input  logic [3:0]             phase_cur,
    input  logic [DIV_W-1:0]       div_cur,
    input  logic [POS_WIDTH-1:0]   pending_cur,
    input  logic [POS_WIDTH-1:0]   position_cur,
    input  logic [7:0]             ovs_cur,
    input  logic                   moving_cur,
    output logic [3:0]             phase_next,
    output logic [DIV_W-1:0]       div_next,
    output logic [POS_WIDTH-1:0]   pending_next,
    output logic [POS_WIDTH-1:0]   position_next,
    output logic [7:0]             ovs_next,
    output logic                   moving_next,
    output sps_flags_t             flags
);

    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(TICKS_PER_STEP);

    logic [DIV_W-1:0]     div_inc;
    logic [15:0]          tgt16;
    logic [31:0]          tgt32;
    logic [31:0]          ofs32;
    logic [31:0]          home32;
    logic [POS_WIDTH-1:0] tgt_ext;
    logic [POS_WIDTH-1:0] ofs_ext;
    logic [POS_WIDTH-1:0] home_ext;

    assign div_inc  = div_cur + 1'b1;
    assign tgt16    = cfg.pos_target[cmd.target_select];
    assign tgt32    = {{16{tgt16[15]}}, tgt16};
    assign ofs32    = {{16{cmd.offset_steps[15]}}, cmd.offset_steps};
    assign home32   = {17'd0, cfg.max_home_steps};
    assign tgt_ext  = tgt32[POS_WIDTH-1:0];
    assign ofs_ext  = ofs32[POS_WIDTH-1:0];
    assign home_ext = home32[POS_WIDTH-1:0];

    always_comb
    begin
        phase_next    = phase_cur;
        div_next      = div_cur;
        pending_next  = pending_cur;
        position_next = position_cur;
        ovs_next      = ovs_cur;
        moving_next   = moving_cur;
        flags         = '0;
        unique case (cmd.action)
            ACT_HOME:
            begin
                position_next = home_ext;
                pending_next  = -home_ext;
                ovs_next      = cfg.overshoot_steps;
                moving_next   = 1'b1;
            end
            ACT_TARGET:
            begin
                pending_next = tgt_ext - position_cur;
                ovs_next     = cfg.overshoot_steps;
                moving_next  = 1'b1;
            end
            ACT_OFFSET:
            begin
                pending_next = ofs_ext;
                ovs_next     = cfg.overshoot_steps;
                moving_next  = 1'b1;
            end
            default:
            begin
                if (moving_cur)
                begin
                    if (div_inc == DIV_LAST)
                    begin
                        div_next = '0;
                        if (pending_cur == '0)
                        begin
                            flags.release_hit = 1'b1;
                            moving_next       = 1'b0;
                        end
                        else if (!pending_cur[POS_WIDTH-1])
                        begin
                            phase_next    = sps_next_phase(phase_cur, cfg.drive_mode, 1'b0);
                            position_next = position_cur + 1'b1;
                            pending_next  = pending_cur - 1'b1;
                            flags.apply   = 1'b1;
                        end
                        else
                        begin
                            flags.apply = 1'b1;
                            if (cmd.at_home && ovs_cur == 8'd0)
                            begin
                                // home reached with no overshoot left: zero out
                                position_next = '0;
                                pending_next  = '0;
                            end
                            else
                            begin
                                if (cmd.at_home)
                                begin
                                    ovs_next = ovs_cur - 8'd1;
                                end
                                phase_next    = sps_next_phase(phase_cur, cfg.drive_mode, 1'b1);
                                position_next = position_cur - 1'b1;
                                pending_next  = pending_cur + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        div_next = div_inc;
                    end
                end
            end
        endcase
    end

endmodule

// ===== hdl/stepper_phase_sequencer.sv =====
// Stepper phase sequencer.
// cmd : one word per tick or command (action, target_select, offset_steps,
//       at_home). Ticks pace the motor; every TICKS_PER_STEP-th tick of a
//       move takes one step or, with nothing pending, releases the coils.
// res : exactly one word per cmd word, in order, showing phase, position,
//       pending and moving after that word, plus phase_apply/release_res.
// cfg : register writes (index, data), always ready; write only while idle.
// Path: a cmd word goes from the input register to the result register,
// which drives res. Throughput: one word per cycle while res.ready is
// high; the step logic is a single add/compare pass between the two.
// Stall: the result register holds while res.ready is low; the input
// register still takes one more word, then cmd.ready drops until the
// result is taken.
// Reset: phase 1, position/pending/divider/overshoot zero, not moving,
// config registers at their default values, both stages empty.
module stepper_phase_sequencer
    import sps_pkg::*;
#(
    parameter int TICKS_PER_STEP = TICKS_PER_STEP_DEF,
    parameter int POS_WIDTH      = POS_WIDTH_DEF,
    localparam int DIV_W         = $clog2(TICKS_PER_STEP + 1)
)
(
    input  logic      clk,
    input  logic      rst_n,
    sps_cmd_if.sink   cmd,
    sps_res_if.source res,
    sps_cfg_if.sink   cfg
);

`include "stepper_phase_sequencer_macros.svh"

    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(TICKS_PER_STEP);

    // Config registers
    sps_cfg_t cfg_reg;

    // Input stage
    logic     in_valid_reg;
    sps_cmd_t in_word_reg;

    // Result stage
    logic     out_valid_reg;
    logic     out_valid_next;
    sps_res_t out_word_reg;
    sps_res_t out_word_next;

    // Motor state
    logic [3:0]           phase_reg;
    logic [3:0]           phase_next;
    logic [DIV_W-1:0]     div_reg;
    logic [DIV_W-1:0]     div_next;
    logic [POS_WIDTH-1:0] pending_reg;
    logic [POS_WIDTH-1:0] pending_next;
    logic [POS_WIDTH-1:0] position_reg;
    logic [POS_WIDTH-1:0] position_next;
    logic [7:0]           ovs_reg;
    logic [7:0]           ovs_next;
    logic                 moving_reg;
    logic                 moving_next;
    sps_flags_t           flags;

    logic        advance;
    logic [31:0] pos32;
    logic [31:0] pend32;

    // The input word moves into the result stage when that stage is free
    // or being emptied this cycle; state commits on the same edge.
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    sps_step #(
        .TICKS_PER_STEP (TICKS_PER_STEP),
        .POS_WIDTH      (POS_WIDTH)
    ) u_step (
        .cfg           (cfg_reg),
        .cmd           (in_word_reg),
        .phase_cur     (phase_reg),
        .div_cur       (div_reg),
        .pending_cur   (pending_reg),
        .position_cur  (position_reg),
        .ovs_cur       (ovs_reg),
        .moving_cur    (moving_reg),
        .phase_next    (phase_next),
        .div_next      (div_next),
        .pending_next  (pending_next),
        .position_next (position_next),
        .ovs_next      (ovs_next),
        .moving_next   (moving_next),
        .flags         (flags)
    );

    // Reported position/pending are the low 16 bits of the state.
    assign pos32  = 32'(position_next);
    assign pend32 = 32'(pending_next);

    always_comb
    begin
        out_word_next.phase       = phase_next;
        out_word_next.phase_apply = flags.apply;
        out_word_next.release_res = flags.release_hit;
        out_word_next.moving      = moving_next;
        out_word_next.position    = pos32[15:0];
        out_word_next.pending     = pend32[15:0];
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Handshake and motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PHASE_RST;
            div_reg       <= '0;
            pending_reg   <= '0;
            position_reg  <= '0;
            ovs_reg       <= '0;
            moving_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                phase_reg    <= phase_next;
                div_reg      <= div_next;
                pending_reg  <= pending_next;
                position_reg <= position_next;
                ovs_reg      <= ovs_next;
                moving_reg   <= moving_next;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_word_reg.action        <= cmd.action;
            in_word_reg.target_select <= cmd.target_select;
            in_word_reg.offset_steps  <= cmd.offset_steps;
            in_word_reg.at_home       <= cmd.at_home;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_mode      <= DRIVE_MODE_RST;
            cfg_reg.overshoot_steps <= OVERSHOOT_RST;
            cfg_reg.max_home_steps  <= MAX_HOME_RST;
            cfg_reg.pos_target[0]   <= POS_DARK_RST;
            cfg_reg.pos_target[1]   <= POS_REFERENCE_RST;
            cfg_reg.pos_target[2]   <= POS_PROD_START_RST;
            cfg_reg.pos_target[3]   <= POS_PROD_END_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DRIVE_MODE:     cfg_reg.drive_mode      <= cfg.data[1:0];
                REG_OVERSHOOT:      cfg_reg.overshoot_steps <= cfg.data[7:0];
                REG_MAX_HOME:       cfg_reg.max_home_steps  <= cfg.data[14:0];
                REG_POS_DARK:       cfg_reg.pos_target[0]   <= cfg.data;
                REG_POS_REFERENCE:  cfg_reg.pos_target[1]   <= cfg.data;
                REG_POS_PROD_START: cfg_reg.pos_target[2]   <= cfg.data;
                REG_POS_PROD_END:   cfg_reg.pos_target[3]   <= cfg.data;
                default:            cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.phase       = out_word_reg.phase;
    assign res.phase_apply = out_word_reg.phase_apply;
    assign res.release_res = out_word_reg.release_res;
    assign res.moving      = out_word_reg.moving;
    assign res.position    = out_word_reg.position;
    assign res.pending     = out_word_reg.pending;

    // Phase never leaves 1..8
    `SPS_ASSERT_NOW(a_phase_range, 1'b1, (phase_reg != 4'd0) && (phase_reg <= 4'd8))
    // Divider wraps before reaching the step count
    `SPS_ASSERT_NOW(a_div_range, 1'b1, div_reg < DIV_LAST)
    // A step and a release never come from the same word
    `SPS_ASSERT_NOW(a_apply_release, out_valid_reg,
                    !(out_word_reg.phase_apply && out_word_reg.release_res))
    // Release always ends the move
    `SPS_ASSERT_NOW(a_release_stops, out_valid_reg && out_word_reg.release_res,
                    !out_word_reg.moving)
    // Any command starts a move
    `SPS_ASSERT_NEXT(a_cmd_moves, advance && (in_word_reg.action != ACT_TICK), moving_reg)

endmodule
